// File: rtl/core/dqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared constants, codes and controller/datapath link types for the
// double-ended queue with linear search.
// ----------------------------------------------------------------------------
package dqs_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic            load;
        logic            push_front;
        logic            push_back;
        logic            pop_front;
        logic            pop_back;
        logic            scan;
        logic            emit;
        logic [ST_W-1:0] emit_status;
        logic            emit_removed;
        logic            emit_pos;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            hit;
        logic            exhausted;
    } t_dp_stat;

endpackage

// File: rtl/core/dqs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_datapath
// Ring store, front index, entry count, scan pipeline and result registers.
// ----------------------------------------------------------------------------
module dqs_datapath #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dqs_pkg::t_dp_cmd                  i_cmd,
    output dqs_pkg::t_dp_stat                 o_stat,
    input  logic [dqs_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [dqs_pkg::VAL_W-1:0]  i_value,
    output logic                              o_strobe,
    output logic [dqs_pkg::ST_W-1:0]          o_status,
    output logic signed [dqs_pkg::VAL_W-1:0]  o_removed_value,
    output logic [dqs_pkg::POS_W-1:0]         o_found_position
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic signed [dqs_pkg::VAL_W-1:0] mem [DEPTH];
    logic signed [dqs_pkg::VAL_W-1:0] r_rdata;
    logic signed [dqs_pkg::VAL_W-1:0] r_val;
    logic [dqs_pkg::OP_W-1:0]         r_op;

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_cmp_k;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_issue;
    logic             r_cmp_vld;

    logic [IDX_W-1:0] head_inc, head_dec, ptr_inc, tail_next, tail_last;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [SUM_W-1:0] sum_next, sum_last;
    logic             issue_ok, rd_en, wr_en;
    logic [dqs_pkg::POS_W-1:0] pos;

    logic                             r_strobe;
    logic [dqs_pkg::ST_W-1:0]         r_status;
    logic signed [dqs_pkg::VAL_W-1:0] r_removed;
    logic [dqs_pkg::POS_W-1:0]        r_pos;

    always_comb begin
        head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
        ptr_inc  = (r_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        sum_next = SUM_W'(r_head) + SUM_W'(r_count);
        sum_last = sum_next - SUM_W'(1);
        tail_next = (sum_next >= SUM_W'(DEPTH)) ? IDX_W'(sum_next - SUM_W'(DEPTH))
                                                : IDX_W'(sum_next);
        tail_last = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                : IDX_W'(sum_last);
        issue_ok = (r_issue != r_count);
        wr_en    = i_cmd.push_front | i_cmd.push_back;
        wr_addr  = i_cmd.push_front ? head_dec : tail_next;
        rd_en    = i_cmd.pop_front | i_cmd.pop_back | (i_cmd.scan & issue_ok);
        if (i_cmd.pop_front) begin
            rd_addr = r_head;
        end else if (i_cmd.pop_back) begin
            rd_addr = tail_last;
        end else begin
            rd_addr = r_ptr;
        end
        pos = dqs_pkg::POS_W'(r_cmp_k) + dqs_pkg::POS_W'(1);
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push_front) begin
            n_head  = head_dec;
            n_count = r_count + 1'b1;
        end else if (i_cmd.push_back) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop_front) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
        end else if (i_cmd.pop_back) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= i_cmd.emit;
            if (i_cmd.load) begin
                r_issue   <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= issue_ok;
                if (issue_ok) begin
                    r_issue <= r_issue + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_val <= i_value;
            r_ptr <= r_head;
        end else if (i_cmd.scan && issue_ok) begin
            r_ptr   <= ptr_inc;
            r_cmp_k <= r_issue[IDX_W-1:0];
        end
        if (i_cmd.emit) begin
            r_status  <= i_cmd.emit_status;
            r_removed <= i_cmd.emit_removed ? r_rdata : '0;
            r_pos     <= i_cmd.emit_pos ? pos : '0;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.hit       = r_cmp_vld && (r_rdata == r_val);
    assign o_stat.exhausted = !issue_ok && !r_cmp_vld;

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_removed_value  = r_removed;
    assign o_found_position = r_pos;

endmodule

// File: rtl/core/dqs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqs_ctrl
// Controller state machine: decodes each command and sequences the pop read
// and the search scan in the datapath.
// ----------------------------------------------------------------------------
module dqs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  dqs_pkg::t_dp_stat  i_stat,
    output dqs_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]       r_state, n_state;
    dqs_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_BACK: begin
                        cmd.emit = 1'b1;
                        if (i_stat.full) begin
                            cmd.emit_status = dqs_pkg::ST_FULL;
                        end else begin
                            cmd.emit_status = dqs_pkg::ST_OK;
                            cmd.push_front  = (i_stat.op == dqs_pkg::OP_PUSH_FRONT);
                            cmd.push_back   = (i_stat.op == dqs_pkg::OP_PUSH_BACK);
                        end
                    end
                    dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_BACK: begin
                        if (i_stat.empty) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = dqs_pkg::ST_EMPTY;
                        end else begin
                            cmd.pop_front = (i_stat.op == dqs_pkg::OP_POP_FRONT);
                            cmd.pop_back  = (i_stat.op == dqs_pkg::OP_POP_BACK);
                            n_state       = S_POP;
                        end
                    end
                    dqs_pkg::OP_SEARCH: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = dqs_pkg::ST_OK;
                    end
                endcase
            end
            S_POP: begin
                cmd.emit         = 1'b1;
                cmd.emit_status  = dqs_pkg::ST_OK;
                cmd.emit_removed = 1'b1;
                n_state          = S_IDLE;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                priority if (i_stat.hit) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = dqs_pkg::ST_OK;
                    cmd.emit_pos    = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_stat.exhausted) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = dqs_pkg::ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE) || !i_rst_n;

endmodule

// File: rtl/core/deque_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of signed 32-bit values with a linear search.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge where start is high and busy is
// low; i_opcode selects push front, push back, pop front, pop back or search
// and i_value carries the value to push or the key to look for.
// Every command gives exactly one result, shown on o_status, o_removed_value
// and o_found_position for a single cycle while o_strobe is high. The
// receiver cannot stall, so each result must be taken in that cycle.
// Pushes, empty pops and unused opcodes emit their result from the execute
// state; a pop that returns a value first reads the ring store and emits
// from the pop state, and a search scans the live entries from the front,
// emitting at the first match or once all are compared. The search reads
// one entry per cycle through the single registered read port of the ring
// store.
// Busy falls in the cycle that the strobe is shown, so the next command can
// be transferred then. Synchronous reset empties the queue and returns the
// controller to idle; busy stays high while reset is asserted. The store
// contents need no clearing since only live entries are ever read.
// ----------------------------------------------------------------------------
module deque_with_search #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dqs_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [dqs_pkg::VAL_W-1:0]  i_value,
    output logic                              o_strobe,
    output logic [dqs_pkg::ST_W-1:0]          o_status,
    output logic signed [dqs_pkg::VAL_W-1:0]  o_removed_value,
    output logic [dqs_pkg::POS_W-1:0]         o_found_position
);

    dqs_pkg::t_dp_cmd  cmd;
    dqs_pkg::t_dp_stat stat;

    dqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_removed_value  (o_removed_value),
        .o_found_position (o_found_position)
    );

    // A transferred command always makes the block busy in the next cycle.
    a_busy_after_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (start && !busy) |=> busy
    ) else $error("busy did not rise after a command transfer");

    // A result only follows a cycle in which a command was in progress.
    a_strobe_from_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_strobe |-> $past(busy)
    ) else $error("result strobe without a command in progress");

    // Two results can never come in consecutive cycles.
    a_strobe_single: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_strobe |=> !o_strobe
    ) else $error("result strobe held for more than one cycle");

endmodule

// File: tb/tb_deque_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_search
// Self-checking bench for the double-ended queue with linear search. A
// driver feeds commands from a pending queue, a shadow ring computes the
// expected result of each accepted command, and a monitor compares every
// strobed result with the oldest expectation. Stimulus is a directed
// opener followed by random fill, drain, mixed and search phases.
// ----------------------------------------------------------------------------
module tb_deque_with_search;
    import dqs_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_SEARCH + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RAND_ITEMS = 1850;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_SEARCH} t_phase;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [VAL_W-1:0]  val;
        bit                       wait_drain;
    } t_cmd;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic signed [VAL_W-1:0]  removed;
        logic [POS_W-1:0]         position;
    } t_reply;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           i_opcode;
    logic signed [VAL_W-1:0]   i_value;
    logic                      o_strobe;
    logic [ST_W-1:0]           o_status;
    logic signed [VAL_W-1:0]   o_removed_value;
    logic [POS_W-1:0]          o_found_position;

    t_cmd   cmd_pending[$];
    t_reply result_due[$];
    logic   cmd_taken = 1'b0;

    logic signed [VAL_W-1:0] ring_mem [DEPTH];
    int ring_head = 0;
    int ring_count = 0;

    int fail_count = 0;
    int sent_count = 0;
    int cnt_full = 0;
    int cnt_empty = 0;
    int cnt_hit = 0;
    int cnt_miss = 0;
    int cnt_deep_hit = 0;
    logic signed [VAL_W-1:0] recent_key = '0;

    deque_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_value(i_value),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_removed_value(o_removed_value),
        .o_found_position(o_found_position)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Applies one command to the shadow ring and returns the result it gives.
    task automatic deque_apply(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                               output t_reply r);
        int k;
        bit hit;
        r.status = ST_OK;
        r.removed = '0;
        r.position = '0;
        hit = 1'b0;
        case (op)
            OP_PUSH_FRONT: begin
                if (ring_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_mem[ring_head] = val;
                    ring_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (ring_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_mem[(ring_head + ring_count) % DEPTH] = val;
                    ring_count++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = ring_mem[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            OP_POP_BACK: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = ring_mem[(ring_head + ring_count - 1) % DEPTH];
                    ring_count--;
                end
            end
            OP_SEARCH: begin
                r.status = ST_NOT_FOUND;
                for (k = 0; k < ring_count; k++) begin
                    if (!hit && ring_mem[(ring_head + k) % DEPTH] == val) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.position = POS_W'(k + 1);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return VAL_MIN;
            2: return VAL_MAX;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
        t_cmd c;
        c.op = op;
        c.val = val;
        c.wait_drain = 1'b0;
        cmd_pending.push_back(c);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            recent_key = val;
        end
    endtask

    task automatic add_drain();
        t_cmd c;
        c.op = OP_PUSH_FRONT;
        c.val = '0;
        c.wait_drain = 1'b1;
        cmd_pending.push_back(c);
    endtask

    // Drives commands at the falling edge; a command stays up until transferred.
    always @(negedge i_clk) begin : drive_cmds
        logic go;
        bit idle_ok;
        t_cmd nxt;
        go = start;
        idle_ok = !(sent_count >= 700 && sent_count < 1150);
        if (i_rst_n && !(start && !cmd_taken)) begin
            go = 1'b0;
            if (cmd_pending.size() > 0) begin
                if (cmd_pending[0].wait_drain) begin
                    if (result_due.size() == 0) begin
                        void'(cmd_pending.pop_front());
                    end
                end else if (!idle_ok || $urandom_range(99) >= 10) begin
                    nxt = cmd_pending.pop_front();
                    go = 1'b1;
                    i_opcode <= nxt.op;
                    i_value <= nxt.val;
                end
            end
        end
        start <= go;
    end

    always @(posedge i_clk) begin : watch_results
        t_reply want;
        t_reply due;
        if (o_strobe === 1'b1) begin
            if (result_due.size() == 0) begin
                $error("result strobed with no command outstanding");
                fail_count++;
            end else begin
                due = result_due.pop_front();
                if (o_status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_status);
                    fail_count++;
                end
                if (o_removed_value !== due.removed) begin
                    $error("removed_value: expected %0d, got %0d", due.removed,
                           o_removed_value);
                    fail_count++;
                end
                if (o_found_position !== due.position) begin
                    $error("found_position: expected %0d, got %0d", due.position,
                           o_found_position);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            deque_apply(i_opcode, i_value, want);
            result_due.push_back(want);
            sent_count++;
            if (want.status == ST_FULL) cnt_full++;
            if (want.status == ST_EMPTY) cnt_empty++;
            if (i_opcode == OP_SEARCH) begin
                if (want.status == ST_OK) cnt_hit++;
                else cnt_miss++;
                if (want.status == ST_OK && want.position == POS_W'(DEPTH)) cnt_deep_hit++;
            end
        end
        cmd_taken <= i_rst_n && start && !busy;
    end

    initial begin : run_ctrl
        int n_rand;
        int plen;
        int i;
        int r;
        t_phase phase;
        logic [OP_W-1:0] op;
        logic signed [VAL_W-1:0] key;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_PUSH_FRONT;
        i_value = '0;

        // Opening checks on an empty queue, the spare opcodes and the value extremes.
        add_cmd(OP_POP_FRONT, VAL_MAX);
        add_cmd(OP_POP_BACK, VAL_MIN);
        add_cmd(OP_SEARCH, '0);
        add_cmd(OP_SPARE_LO, VAL_MAX);
        add_cmd(OP_SPARE_LO + 3'd1, -32'sd1);
        add_cmd(OP_SPARE_HI, VAL_MIN);
        add_cmd(OP_PUSH_BACK, VAL_MAX);
        add_cmd(OP_PUSH_FRONT, VAL_MIN);
        add_cmd(OP_PUSH_BACK, -32'sd1);
        add_cmd(OP_SEARCH, VAL_MIN);
        add_cmd(OP_SEARCH, -32'sd1);
        add_cmd(OP_SEARCH, '0);
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_POP_FRONT, '0);
        add_cmd(OP_POP_FRONT, '0);
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_PUSH_FRONT, '0);
        add_cmd(OP_SEARCH, '0);
        add_cmd(OP_POP_BACK, VAL_MAX);
        add_drain();

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            phase = t_phase'($urandom_range(3));
            plen = $urandom_range(10, 50);
            for (i = 0; i < plen; i++) begin
                r = $urandom_range(99);
                case (phase)
                    PH_FILL: r = (r < 80) ? r % 2 : (r < 90) ? 2 + r % 2 : 4;
                    PH_DRAIN: r = (r < 80) ? 2 + r % 2 : (r < 90) ? r % 2 : 4;
                    PH_SEARCH: r = (r < 60) ? 4 : r % 4;
                    default: r = (r < 2) ? 5 : r % 5;
                endcase
                case (r)
                    0: op = OP_PUSH_FRONT;
                    1: op = OP_PUSH_BACK;
                    2: op = OP_POP_FRONT;
                    3: op = OP_POP_BACK;
                    4: op = OP_SEARCH;
                    default: op = OP_SPARE_LO + OP_W'($urandom_range(2));
                endcase
                if (op == OP_SEARCH) begin
                    r = $urandom_range(9);
                    key = (r < 4) ? recent_key : pick_value();
                end else begin
                    key = pick_value();
                end
                add_cmd(op, key);
                if (op <= OP_SEARCH) n_rand++;
            end
            if ($urandom_range(9) == 0) add_drain();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_pending.size() != 0 || start || result_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Covered %0d transfers: %0d pushes refused as full, %0d pops on empty.",
                 sent_count, cnt_full, cnt_empty);
        $display("Searches: %0d hits (%0d at the deepest slot), %0d misses.",
                 cnt_hit, cnt_deep_hit, cnt_miss);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : run_limit
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
